// File: rtl/lcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared widths, codes and types of the load-cell tare and calibrate scaler.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int KIND_W      = 2;
    localparam int SAMPLE_W    = 24;
    localparam int OFFSET_W    = 24;
    localparam int COEFF_W     = 25;
    localparam int WEIGHT_W    = 25;
    localparam int MASS_W      = 16;
    localparam int SUM_W       = 28;
    localparam int CNT_W       = 4;
    localparam int RUN_LENGTH  = 10;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 25;

    localparam int DIV_N_W     = SUM_W;
    localparam int DIV_D_W     = COEFF_W;
    localparam int DIV_STEPS   = DIV_N_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // The run average is the sum times a rounded-up reciprocal of the run
    // length. Four shift bits beyond the sum width keep the floor exact for
    // every sum the run can reach.
    localparam int     RECIP_SHIFT = SUM_W + 4;
    localparam longint RUN_RECIP   = ((longint'(1) <<< RECIP_SHIFT) + longint'(RUN_LENGTH)
                                      - longint'(1)) / longint'(RUN_LENGTH);
    localparam int     RECIP_W     = $clog2(RUN_RECIP + 1);
    localparam int     PROD_W      = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0]  RUN_RECIP_K  = RECIP_W'(RUN_RECIP);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;
    localparam logic [COEFF_W-1:0]  COEFF_RESET  = COEFF_W'(1);
    localparam logic [MASS_W-1:0]   MASS_RESET   = MASS_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_MEASURE = 2'd0,
        KIND_TARE    = 2'd1,
        KIND_CAL     = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KNOWN_MASS    = 2'd0,
        CFG_OFFSET_PRESET = 2'd1,
        CFG_COEFF_PRESET  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_MEASURE,
        OP_ACCUM,
        OP_TARE_END,
        OP_CAL_END
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SUM_W-1:0] arg;
    } t_cmd;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS,
        ST_TARE,
        ST_CAL_AVG,
        ST_CAL_DIV
    } t_back_state;

endpackage
`default_nettype wire

// File: rtl/lcs_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_in_if
// Input item channel: kind tag and raw converter sample.
// ----------------------------------------------------------------------------
interface lcs_in_if import lcs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface
`default_nettype wire

// File: rtl/lcs_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_out_if
// Result item channel: weight, working offset and coefficient, status flags.
// ----------------------------------------------------------------------------
interface lcs_out_if import lcs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight;
    logic [OFFSET_W-1:0]        offset_now;
    logic signed [COEFF_W-1:0]  coeff_now;
    logic                       run_done;
    logic                       error;

    modport source (output valid, output weight, output offset_now, output coeff_now,
                    output run_done, output error, input ready);
    modport sink   (input valid, input weight, input offset_now, input coeff_now,
                    input run_done, input error, output ready);
endinterface
`default_nettype wire

// File: rtl/load_cell_tare_calibrate_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// load_cell_tare_calibrate_scale
// Load-cell scaler with run-averaged tare and calibration.
//
//   Channel    Dir  Handshake     Payload
//   i_item     in   valid/ready   kind, sample
//   o_result   out  valid/ready   weight, offset_now, coeff_now, run_done, error
//   i_cfg_*    in   write enable  register index, data
//
// A tare or calibrate sample that does not end its run, and a measure with
// zero coefficient, give their result straight from the queued command.
// Tare-end first forms the run average as a reciprocal product. Measure
// waits on the 28-step bit-serial divider; calibrate-end takes the
// average, then one divider pass.
// Reset is synchronous: offset 0, coefficient 1, known mass 1, no run open.
// A two-entry command queue keeps the front accepting while the back end
// divides or its result waits; once it is full the input stalls.
// ----------------------------------------------------------------------------
module load_cell_tare_calibrate_scale import lcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    lcs_in_if.sink                    i_item,
    lcs_out_if.source                 o_result
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    lcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (q_full)
    );

    lcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    lcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire

// File: rtl/lcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_front
// Accepts items, tracks the tare/calibrate run and sums its samples, and
// turns each item into one command for the back end.
// ----------------------------------------------------------------------------
module lcs_front import lcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lcs_in_if.sink    i_item,
    output logic      o_push,
    output t_cmd      o_cmd,
    input  wire logic i_full
);

    logic [KIND_W-1:0] r_run_kind, n_run_kind;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic             is_run;
    logic             same_run;
    logic [SUM_W-1:0] sum_inc;
    logic [CNT_W-1:0] cnt_inc;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        is_run   = (i_item.kind == KIND_TARE) || (i_item.kind == KIND_CAL);
        same_run = (r_run_kind == i_item.kind);
        sum_inc  = (same_run ? r_sum : '0) + SUM_W'(i_item.sample);
        cnt_inc  = (same_run ? r_cnt : '0) + CNT_W'(1);

        n_run_kind = '0;
        n_sum      = '0;
        n_cnt      = '0;
        o_cmd.arg  = sum_inc;

        if (is_run) begin
            if (cnt_inc >= CNT_W'(RUN_LENGTH)) begin
                o_cmd.op = (i_item.kind == KIND_TARE) ? OP_TARE_END : OP_CAL_END;
            end else begin
                o_cmd.op   = OP_ACCUM;
                n_run_kind = i_item.kind;
                n_sum      = sum_inc;
                n_cnt      = cnt_inc;
            end
        end else begin
            // Measure (and the unused fourth code) abandons any open run.
            o_cmd.op  = OP_MEASURE;
            o_cmd.arg = SUM_W'(i_item.sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_kind <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else if (o_push) begin
            r_run_kind <= n_run_kind;
            r_sum      <= n_sum;
            r_cnt      <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lcs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lcs_queue import lcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/lcs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcs_div import lcs_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_dvs;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_N_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = (shifted >= {1'b0, r_dvs});
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below the divisor, so it fits the divisor width.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// File: rtl/lcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_back
// Executes commands: weight division, tare average and calibration, holds
// the working offset and coefficient, and registers the result item.
// ----------------------------------------------------------------------------
module lcs_back import lcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_q_valid,
    input  wire t_cmd                 i_q_cmd,
    output logic                      o_q_pop,
    lcs_out_if.source                 o_result
);

    t_back_state                r_state, n_state;
    logic [OFFSET_W-1:0]        r_offset, n_offset;
    logic signed [COEFF_W-1:0]  r_coeff, n_coeff;
    logic [MASS_W-1:0]          r_mass, n_mass;
    logic                       r_neg, n_neg;
    logic [OFFSET_W-1:0]        r_avg, n_avg;
    logic                       r_out_valid, n_out_valid;
    logic signed [WEIGHT_W-1:0] r_weight, n_weight;
    logic                       r_run_done, n_run_done;
    logic                       r_error, n_error;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [PROD_W-1:0]         avg_prod;
    logic signed [COEFF_W-1:0] meas_diff;
    logic [COEFF_W-1:0]        meas_mag;
    logic [COEFF_W-1:0]        coeff_mag;
    logic signed [COEFF_W-1:0] cal_diff;
    logic [COEFF_W-1:0]        cal_mag;
    logic [MASS_W-1:0]         mass_eff;
    logic signed [COEFF_W-1:0] quot_s;
    logic signed [COEFF_W-1:0] div_res;

    lcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        avg_prod  = i_q_cmd.arg * RUN_RECIP_K;
        meas_diff = $signed({1'b0, i_q_cmd.arg[SAMPLE_W-1:0]}) - $signed({1'b0, r_offset});
        meas_mag  = meas_diff[COEFF_W-1] ? COEFF_W'(-meas_diff) : COEFF_W'(meas_diff);
        coeff_mag = r_coeff[COEFF_W-1] ? COEFF_W'(-r_coeff) : COEFF_W'(r_coeff);
        cal_diff  = $signed({1'b0, r_avg}) - $signed({1'b0, r_offset});
        cal_mag   = cal_diff[COEFF_W-1] ? COEFF_W'(-cal_diff) : COEFF_W'(cal_diff);
        // A zero mass divides by one instead.
        mass_eff  = (r_mass == '0) ? MASS_W'(1) : r_mass;
        quot_s    = $signed(div_rsp.quot[COEFF_W-1:0]);
        div_res   = r_neg ? -quot_s : quot_s;
    end

    always_comb begin
        n_state     = r_state;
        n_offset    = r_offset;
        n_coeff     = r_coeff;
        n_mass      = r_mass;
        n_neg       = r_neg;
        n_avg       = r_avg;
        n_out_valid = r_out_valid && !o_result.ready;
        n_weight    = r_weight;
        n_run_done  = r_run_done;
        n_error     = r_error;
        o_q_pop     = 1'b0;
        div_req     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.op)
                        OP_ACCUM: begin
                            n_out_valid = 1'b1;
                            n_weight    = '0;
                            n_run_done  = 1'b0;
                            n_error     = 1'b0;
                        end
                        OP_MEASURE: begin
                            if (r_coeff == '0) begin
                                n_out_valid = 1'b1;
                                n_weight    = '0;
                                n_run_done  = 1'b0;
                                n_error     = 1'b1;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_N_W'(meas_mag);
                                div_req.divisor  = coeff_mag;
                                n_neg            = meas_diff[COEFF_W-1] ^ r_coeff[COEFF_W-1];
                                n_state          = ST_MEAS;
                            end
                        end
                        OP_TARE_END: begin
                            n_avg   = avg_prod[RECIP_SHIFT +: OFFSET_W];
                            n_state = ST_TARE;
                        end
                        OP_CAL_END: begin
                            n_avg   = avg_prod[RECIP_SHIFT +: OFFSET_W];
                            n_state = ST_CAL_AVG;
                        end
                    endcase
                end
            end
            ST_MEAS: begin
                if (div_rsp.done) begin
                    n_out_valid = 1'b1;
                    n_weight    = div_res;
                    n_run_done  = 1'b0;
                    n_error     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_TARE: begin
                n_offset    = r_avg;
                n_out_valid = 1'b1;
                n_weight    = '0;
                n_run_done  = 1'b1;
                n_error     = 1'b0;
                n_state     = ST_IDLE;
            end
            ST_CAL_AVG: begin
                // The run average is ready; now divide its distance from the
                // offset by the reference mass.
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'(cal_mag);
                div_req.divisor  = DIV_D_W'(mass_eff);
                n_neg            = cal_diff[COEFF_W-1];
                n_state          = ST_CAL_DIV;
            end
            ST_CAL_DIV: begin
                if (div_rsp.done) begin
                    n_coeff     = div_res;
                    n_out_valid = 1'b1;
                    n_weight    = '0;
                    n_run_done  = 1'b1;
                    n_error     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KNOWN_MASS:    n_mass   = i_cfg_data[MASS_W-1:0];
                CFG_OFFSET_PRESET: n_offset = i_cfg_data[OFFSET_W-1:0];
                CFG_COEFF_PRESET:  n_coeff  = $signed(i_cfg_data[COEFF_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_offset    <= OFFSET_RESET;
            r_coeff     <= $signed(COEFF_RESET);
            r_mass      <= MASS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_offset    <= n_offset;
            r_coeff     <= n_coeff;
            r_mass      <= n_mass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_avg      <= n_avg;
        r_weight   <= n_weight;
        r_run_done <= n_run_done;
        r_error    <= n_error;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.weight     = r_weight;
    assign o_result.offset_now = r_offset;
    assign o_result.coeff_now  = r_coeff;
    assign o_result.run_done   = r_run_done;
    assign o_result.error      = r_error;

`ifndef SYNTHESIS
    a_pop_needs_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !r_out_valid)
        else $error("command popped while a result is still pending");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while back end is idle");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state != ST_IDLE))
        else $error("divider finished with nobody waiting");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result pending while a command is in progress");
`endif

endmodule
`default_nettype wire

// File: verif/lcs_result_check.sv
// ----------------------------------------------------------------------------
// lcs_result_check
// Follows the item, result and register-write traffic of the load-cell
// scaler and predicts each result from its own offset, coefficient and run
// state. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lcs_result_check import lcs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    lcs_in_if                         i_item,
    lcs_out_if                        i_result,
    output int                        o_mismatches,
    output int                        o_pending
);

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [OFFSET_W-1:0] offset_now;
        logic [COEFF_W-1:0]  coeff_now;
        logic                run_done;
        logic                error;
    } t_reading;

    logic [MASS_W-1:0]         known_mass_val;
    logic [OFFSET_W-1:0]       offset_val;
    logic signed [COEFF_W-1:0] coeff_val;
    logic [SUM_W-1:0]          run_sum;
    logic [CNT_W-1:0]          run_count;
    logic [KIND_W-1:0]         run_kind;
    t_reading                  expected_readings[$];
    int                        results_seen = 0;

    initial o_mismatches = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("result_check: %s", msg);
        o_mismatches++;
    endtask

    task automatic compare_field(input string name, input logic signed [WEIGHT_W:0] want,
                                 input logic signed [WEIGHT_W:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s: expected %0d, got %0d",
                                      results_seen, name, want, got));
        end
    endtask

    // Advances the run and scaling state by one item and returns its result.
    function automatic t_reading predict_reading(input logic [KIND_W-1:0] kind,
                                                 input logic [SAMPLE_W-1:0] sample);
        t_reading            r;
        longint              diff;
        longint              divisor;
        longint              quot;
        logic [OFFSET_W-1:0] avg;
        r = '0;
        if (kind == KIND_TARE || kind == KIND_CAL) begin
            // A change of kind throws away whatever the open run had gathered.
            if (run_kind != kind) begin
                run_kind  = kind;
                run_sum   = '0;
                run_count = '0;
            end
            run_sum   = run_sum + SUM_W'(sample);
            run_count = run_count + CNT_W'(1);
            if (run_count >= CNT_W'(RUN_LENGTH)) begin
                avg = OFFSET_W'(run_sum / RUN_LENGTH);
                if (kind == KIND_TARE) begin
                    offset_val = avg;
                end else begin
                    diff      = $signed({1'b0, avg}) - $signed({1'b0, offset_val});
                    divisor   = (known_mass_val == '0) ? 1 : known_mass_val;
                    quot      = diff / divisor;
                    coeff_val = quot[COEFF_W-1:0];
                end
                r.run_done = 1'b1;
                run_kind   = KIND_MEASURE;
                run_sum    = '0;
                run_count  = '0;
            end
        end else begin
            // Measure, and the spare kind code, close any open run.
            run_kind  = KIND_MEASURE;
            run_sum   = '0;
            run_count = '0;
            if (coeff_val == '0) begin
                r.error = 1'b1;
            end else begin
                diff     = $signed({1'b0, sample}) - $signed({1'b0, offset_val});
                divisor  = coeff_val;
                quot     = diff / divisor;
                r.weight = quot[WEIGHT_W-1:0];
            end
        end
        r.offset_now = offset_val;
        r.coeff_now  = coeff_val;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reading want;
        if (!i_rst_n) begin
            known_mass_val = MASS_RESET;
            offset_val     = OFFSET_RESET;
            coeff_val      = COEFF_RESET;
            run_sum        = '0;
            run_count      = '0;
            run_kind       = KIND_MEASURE;
            expected_readings.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                results_seen++;
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("weight", $signed(want.weight), $signed(i_result.weight));
                    compare_field("offset_now", want.offset_now, i_result.offset_now);
                    compare_field("coeff_now", $signed(want.coeff_now),
                                  $signed(i_result.coeff_now));
                    compare_field("run_done", want.run_done, i_result.run_done);
                    compare_field("error", want.error, i_result.error);
                end
            end
            // Preset writes load the working values at once.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KNOWN_MASS:    known_mass_val = i_cfg_data[MASS_W-1:0];
                    CFG_OFFSET_PRESET: offset_val     = i_cfg_data[OFFSET_W-1:0];
                    CFG_COEFF_PRESET:  coeff_val      = i_cfg_data[COEFF_W-1:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                expected_readings.push_back(predict_reading(i_item.kind, i_item.sample));
            end
        end
        o_pending <= expected_readings.size();
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the load-cell scaler with directed and random measure, tare and
// calibrate items under a range of register settings, with random gaps on
// both channels, and gives the verdict from the result checker.
// ----------------------------------------------------------------------------
module testbench;
    import lcs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int HOLD_PHASE      = 1;
    localparam int FLOOD_ITEMS     = 40;
    localparam int RX_HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES     = 120;
    localparam int CYCLE_LIMIT     = 1000000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   pending;
    int                   cycles = 0;
    bit                   hold_req = 1'b0;
    bit                   tx_flood = 1'b0;
    bit                   tx_eager = 1'b0;
    int                   tx_stretch = 0;
    int                   tare_base = 0;

    lcs_in_if  item_if ();
    lcs_out_if result_if ();

    load_cell_tare_calibrate_scale dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    lcs_result_check result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_item       (item_if),
        .i_result     (result_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Gaps come in stretches: some with none at all, others mostly short
    // with an occasional long one.
    function automatic int next_gap();
        int r;
        if (tx_stretch == 0) begin
            tx_eager   = ($urandom_range(0, 2) == 0);
            tx_stretch = $urandom_range(10, 120);
        end
        tx_stretch--;
        if (tx_eager || tx_flood) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_base();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return SAMPLE_MAX;
        if (r < 6) return tare_base;
        return $urandom_range(0, SAMPLE_MAX);
    endfunction

    function automatic int pick_spread();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 255;
        if (r < 8) return 65535;
        return SAMPLE_MAX;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_near(input int base, input int spread);
        int s;
        s = base + int'($urandom_range(0, spread));
        if (s > SAMPLE_MAX) begin
            s = SAMPLE_MAX;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    task automatic push_item(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] sample);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid  <= 1'b1;
        item_if.kind   <= kind;
        item_if.sample <= sample;
        do @(posedge clk); while (!item_if.ready);
    endtask

    // The pending count is registered, so the loop waits on the clock before its first look.
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int phase);
        logic [MASS_W-1:0]   mass;
        logic [OFFSET_W-1:0] offs;
        logic [COEFF_W-1:0]  coef;
        mass = MASS_W'($urandom_range(1, 16'hFFFF));
        offs = OFFSET_W'($urandom_range(0, SAMPLE_MAX));
        coef = COEFF_W'(int'($urandom_range(0, 600)) - 300);
        case (phase)
            0: begin
                mass = 16'd1;
                offs = '0;
                coef = COEFF_W'(1);
            end
            1: begin
                mass = 16'hFFFF;
                offs = 24'hFFFFFF;
                coef = '1;
            end
            2: begin
                mass = '0;
                coef = '0;
            end
            3: coef = 25'h0FFFFFF;
            4: begin
                mass = MASS_W'($urandom_range(1, 100));
                offs = '0;
                coef = 25'h1000000;
            end
            5: coef = 25'h1000001;
            default: ;
        endcase
        write_reg(CFG_KNOWN_MASS, CFG_W'(mass));
        write_reg(CFG_OFFSET_PRESET, CFG_W'(offs));
        write_reg(CFG_COEFF_PRESET, coef);
        cfg_we <= 1'b0;
    endtask

    // Mostly complete ten-sample runs, with broken runs, measures and the
    // spare kind code mixed in.
    task automatic random_items(input int count);
        int                sent;
        int                n;
        int                i;
        int                pick;
        int                base;
        int                spread;
        logic [KIND_W-1:0] kind;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            n    = RUN_LENGTH;
            if (pick < 30) begin
                kind = KIND_TARE;
            end else if (pick < 60) begin
                kind = KIND_CAL;
            end else if (pick < 72) begin
                kind = $urandom_range(0, 1) ? KIND_TARE : KIND_CAL;
                n    = $urandom_range(1, RUN_LENGTH - 1);
            end else if (pick < 77) begin
                kind = KIND_SPARE;
                n    = $urandom_range(1, 2);
            end else begin
                kind = KIND_MEASURE;
                n    = $urandom_range(1, 5);
            end
            base   = pick_base();
            spread = pick_spread();
            if (kind == KIND_TARE) begin
                tare_base = base;
            end
            for (i = 0; i < n; i++) begin
                push_item(kind, sample_near(base, spread));
            end
            sent += n;
        end
    endtask

    initial begin : result_sink
        int  stall_left;
        int  stretch_left;
        bit  eager;
        bit  held;
        stall_left   = 0;
        stretch_left = 0;
        eager        = 1'b0;
        held         = 1'b0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held       = 1'b1;
                stall_left = RX_HOLD_CYCLES;
            end
            if (stretch_left == 0) begin
                eager        = ($urandom_range(0, 2) == 0);
                stretch_left = $urandom_range(20, 300);
            end
            stretch_left--;
            if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (eager) begin
                result_if.ready <= 1'b1;
            end else if ($urandom_range(0, 63) == 0) begin
                stall_left = $urandom_range(15, 50);
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin : stimulus
        int phase;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_KNOWN_MASS;
        cfg_data       <= '0;
        item_if.valid  <= 1'b0;
        item_if.kind   <= KIND_MEASURE;
        item_if.sample <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset register values.
        push_item(KIND_MEASURE, '0);
        push_item(KIND_MEASURE, 24'hFFFFFF);
        push_item(KIND_SPARE, 24'h5A5A5A);
        repeat (3) push_item(KIND_TARE, 24'h000100);
        repeat (2) push_item(KIND_CAL, 24'hA00000);
        push_item(KIND_MEASURE, 24'h123456);
        repeat (RUN_LENGTH) push_item(KIND_TARE, 24'hFFFFFF);
        push_item(KIND_MEASURE, '0);
        wait_drained();
        write_reg(CFG_COEFF_PRESET, '0);
        cfg_we <= 1'b0;
        push_item(KIND_MEASURE, 24'h800000);
        wait_drained();

        for (phase = 0; phase < N_PHASES; phase++) begin
            apply_setting(phase);
            if (phase == HOLD_PHASE) begin
                // The result side holds off while items keep coming.
                hold_req <= 1'b1;
                tx_flood = 1'b1;
                random_items(FLOOD_ITEMS);
                tx_flood = 1'b0;
                random_items(ITEMS_PER_PHASE - FLOOD_ITEMS);
            end else begin
                random_items(ITEMS_PER_PHASE);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/lcs_pkg.sv
rtl/lcs_in_if.sv
rtl/lcs_out_if.sv
rtl/lcs_front.sv
rtl/lcs_queue.sv
rtl/lcs_div.sv
rtl/lcs_back.sv
rtl/load_cell_tare_calibrate_scale.sv
verif/lcs_result_check.sv
verif/testbench.sv
